// ===== hdl/twt_pkg.sv =====
// shared types and codes of the timeline wait table
`timescale 1ns / 1ps

package twt_pkg;

  // operation carried by an input item
  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_NOTIFY   = 2'd1,
    OP_CHECK    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // kind of a result item
  typedef enum logic [1:0] {
    KIND_RELEASED = 2'd0,
    KIND_TIMEOUT  = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  localparam int unsigned FIELD_TASK_BITS   = 16;
  localparam int unsigned FIELD_HANDLE_BITS = 32;
  localparam int unsigned FIELD_COUNT_BITS  = 5;

endpackage

// ===== hdl/twt_in_if.sv =====
// command channel of the timeline wait table
`timescale 1ns / 1ps

interface twt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] timeline_handle;
  logic [63:0] sync_value;
  logic [31:0] timeout_ms;
  logic [31:0] now_ms;
  logic [15:0] task_id;
  logic        task_present;

  modport source (
    output valid, opcode, timeline_handle, sync_value, timeout_ms, now_ms, task_id,
           task_present,
    input  ready
  );

  modport sink (
    input  valid, opcode, timeline_handle, sync_value, timeout_ms, now_ms, task_id,
           task_present,
    output ready
  );
endinterface

// ===== hdl/twt_out_if.sv =====
// result channel of the timeline wait table
`timescale 1ns / 1ps

interface twt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] released_task;
  logic [4:0]  step_count;
  logic [4:0]  pending_now;
  logic        any_timeout;
  logic        timeout_sticky;
  logic        table_full;
  logic        last;

  modport source (
    output valid, kind, released_task, step_count, pending_now, any_timeout,
           timeout_sticky, table_full, last,
    input  ready
  );

  modport sink (
    input  valid, kind, released_task, step_count, pending_now, any_timeout,
           timeout_sticky, table_full, last,
    output ready
  );
endinterface

// ===== hdl/twt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module twt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/twt_match.sv =====
// per-slot test: handle and target on notify, elapsed time on timeout check
`timescale 1ns / 1ps

module twt_match #(
  parameter int unsigned HB = 32
) (
  input  twt_pkg::op_t  op,
  input  logic [HB-1:0] handle,
  input  logic [63:0]   value,
  input  logic [31:0]   now,
  input  logic [HB-1:0] slot_handle,
  input  logic [63:0]   slot_target,
  input  logic [31:0]   slot_timeout,
  input  logic [31:0]   slot_start,
  output logic          hit
);

  logic [31:0] elapsed;

  always_comb begin
    elapsed = now - slot_start;
    if (op == twt_pkg::OP_CHECK) begin
      hit = (elapsed >= slot_timeout);
    end else begin
      hit = (slot_handle == handle) && (slot_target <= value);
    end
  end

endmodule

// ===== hdl/timeline_wait_table.sv =====
// top level of the timeline wait table: sequencer, slot store and result register
`timescale 1ns / 1ps

// timeline wait table
// cmd carries one operation per item: register a waiter, notify a timeline
// advance, check timeouts, or clear the table. res carries result items: one
// item per released or timed-out task (in slot order) and then one summary
// item with last set, which ends the run of that command.
// register and clear: the command item moves the sequencer to the summary
// state, which loads the summary into the result register once that register
// is free; the next command is taken after the summary is loaded. notify and
// check scan every slot through the slot ram, one slot per cycle while no
// report waits on a stalled receiver: each slot is read from the ram, its
// record is tested on the ram output, and a hit with a task is reported into the
// result register; after the last slot the summary state loads the summary and
// the sequencer returns to idle. one command is in work at a time; cmd.ready is
// high while the sequencer is idle, also while a finished result still waits.
// a stalled receiver holds the result register and freezes the scan on the
// slot whose report waits; nothing is dropped.
// reset (rst, synchronous) clears all pending flags, the pending count, the
// sticky timeout flag and empties the result register; no clearing pass is
// needed because slot contents are only read after they are written.
module timeline_wait_table #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned HANDLE_BITS = 32,
  parameter int unsigned TASK_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  twt_in_if.sink    cmd,
  twt_out_if.source res
);

  // widths derived from the parameters
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned HB = (HANDLE_BITS < twt_pkg::FIELD_HANDLE_BITS) ?
                               HANDLE_BITS : twt_pkg::FIELD_HANDLE_BITS;
  localparam int unsigned TB = (TASK_BITS < twt_pkg::FIELD_TASK_BITS) ?
                               TASK_BITS : twt_pkg::FIELD_TASK_BITS;
  // slot record: present, task, handle, target, timeout, start time
  localparam int unsigned RW = 1 + TB + HB + 64 + 32 + 32;

  // control state
  twt_pkg::state_t state;
  logic [ENTRIES-1:0] pend;       // slot holds a waiter not yet satisfied
  logic [CW-1:0]      count;      // number of pending slots
  logic               sticky;     // timeout seen since last clear

  // latched command
  twt_pkg::op_t  op;
  logic [HB-1:0] s_handle;
  logic [63:0]   s_value;
  logic [31:0]   s_now;
  logic          full;
  logic [CW-1:0] step_cnt;
  logic          anyto;

  // scan pointers
  logic [CW-1:0] rd_idx;      // next slot to read
  logic [AW-1:0] eval_idx;    // slot whose data is on the ram output
  logic          eval_valid;

  // result register
  logic                   out_valid;
  twt_pkg::kind_t         out_kind;
  logic [15:0]            out_task;
  logic [4:0]             out_cnt;
  logic [4:0]             out_pend;
  logic                   out_anyto;
  logic                   out_sticky;
  logic                   out_full;
  logic                   out_last;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // unpacked slot record on the ram output
  logic          rd_present;
  logic [TB-1:0] rd_task;
  logic [HB-1:0] rd_handle;
  logic [63:0]   rd_target;
  logic [31:0]   rd_tmo;
  logic [31:0]   rd_start;

  // decode and scan control
  twt_pkg::op_t  op_in;
  logic [AW-1:0] sel_free;
  logic          any_free;
  logic          match_hit;
  logic          hit_q;
  logic          report;
  logic          out_free;
  logic          advance;
  logic          issue;
  logic          out_load;

  assign {rd_present, rd_task, rd_handle, rd_target, rd_tmo, rd_start} = ram_rdata;

  twt_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  twt_match #(
    .HB (HB)
  ) u_match (
    .op           (op),
    .handle       (s_handle),
    .value        (s_value),
    .now          (s_now),
    .slot_handle  (rd_handle),
    .slot_target  (rd_target),
    .slot_timeout (rd_tmo),
    .slot_start   (rd_start),
    .hit          (match_hit)
  );

  // lowest slot that is free or already satisfied
  always_comb begin
    sel_free = '0;
    any_free = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!pend[i]) begin
        sel_free = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    op_in    = twt_pkg::op_t'(cmd.opcode);
    hit_q    = eval_valid && pend[eval_idx] && match_hit;
    report   = hit_q && rd_present;
    out_free = !out_valid || res.ready;
    // freeze the scan while a report waits for the result register
    advance  = !(report && !out_free);
    issue    = advance && (rd_idx < CW'(ENTRIES));
    // result register takes a report or the summary
    out_load = ((state == twt_pkg::S_SCAN) && report && advance) ||
               ((state == twt_pkg::S_SUM) && out_free);
    // on a stall re-read the same slot so the ram output holds
    ram_raddr = advance ? rd_idx[AW-1:0] : eval_idx;

    ram_we    = (state == twt_pkg::S_IDLE) && cmd.valid &&
                (op_in == twt_pkg::OP_REGISTER) && any_free;
    ram_waddr = sel_free;
    ram_wdata = {cmd.task_present, cmd.task_id[TB-1:0], cmd.timeline_handle[HB-1:0],
                 cmd.sync_value, cmd.timeout_ms, cmd.now_ms};
  end

  assign cmd.ready = (state == twt_pkg::S_IDLE);

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.released_task  = out_task;
  assign res.step_count     = out_cnt;
  assign res.pending_now    = out_pend;
  assign res.any_timeout    = out_anyto;
  assign res.timeout_sticky = out_sticky;
  assign res.table_full     = out_full;
  assign res.last           = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= twt_pkg::S_IDLE;
      pend       <= '0;
      count      <= '0;
      sticky     <= 1'b0;
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // held until taken, reloaded when a new item is written
      out_valid <= out_load || (out_valid && !res.ready);

      unique case (state)
        twt_pkg::S_IDLE: begin
          if (cmd.valid) begin
            op         <= op_in;
            s_handle   <= cmd.timeline_handle[HB-1:0];
            s_value    <= cmd.sync_value;
            s_now      <= cmd.now_ms;
            full       <= 1'b0;
            step_cnt   <= '0;
            anyto      <= 1'b0;
            rd_idx     <= '0;
            eval_valid <= 1'b0;
            unique case (op_in)
              twt_pkg::OP_REGISTER: begin
                if (any_free) begin
                  pend[sel_free] <= 1'b1;
                  count          <= count + 1'b1;
                end else begin
                  full <= 1'b1;
                end
                state <= twt_pkg::S_SUM;
              end
              twt_pkg::OP_NOTIFY, twt_pkg::OP_CHECK: begin
                state <= twt_pkg::S_SCAN;
              end
              twt_pkg::OP_CLEAR: begin
                pend   <= '0;
                count  <= '0;
                sticky <= 1'b0;
                state  <= twt_pkg::S_SUM;
              end
              default: begin
                state <= twt_pkg::S_SUM;
              end
            endcase
          end
        end

        twt_pkg::S_SCAN: begin
          // settle the slot on the ram output
          if (hit_q && advance) begin
            pend[eval_idx] <= 1'b0;
            count          <= count - 1'b1;
            if (op == twt_pkg::OP_CHECK) begin
              anyto  <= 1'b1;
              sticky <= 1'b1;
            end else if (rd_present) begin
              step_cnt <= step_cnt + 1'b1;
            end
          end
          // report a released or timed-out task
          if (report && advance) begin
            out_kind   <= (op == twt_pkg::OP_CHECK) ? twt_pkg::KIND_TIMEOUT :
                                                      twt_pkg::KIND_RELEASED;
            out_task   <= 16'(rd_task);
            out_cnt    <= '0;
            out_pend   <= '0;
            out_anyto  <= 1'b0;
            out_sticky <= 1'b0;
            out_full   <= 1'b0;
            out_last   <= 1'b0;
          end
          // move to the next slot
          if (advance) begin
            if (issue) begin
              eval_valid <= 1'b1;
              eval_idx   <= rd_idx[AW-1:0];
              rd_idx     <= rd_idx + 1'b1;
            end else begin
              eval_valid <= 1'b0;
              if (!eval_valid) begin
                state <= twt_pkg::S_SUM;
              end
            end
          end
        end

        twt_pkg::S_SUM: begin
          if (out_free) begin
            out_kind   <= twt_pkg::KIND_SUMMARY;
            out_task   <= '0;
            out_cnt    <= 5'(step_cnt);
            out_pend   <= 5'(count);
            out_anyto  <= anyto;
            out_sticky <= sticky;
            out_full   <= full;
            out_last   <= 1'b1;
            state      <= twt_pkg::S_IDLE;
          end
        end

        default: begin
          state <= twt_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
